[hdl/serial_command_retry_engine_macros.svh]
// Assertion macros used by the checker file of the serial command retry engine.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef SERIAL_COMMAND_RETRY_ENGINE_MACROS_SVH
`define SERIAL_COMMAND_RETRY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCRE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCRE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/scre_pkg.sv]
// Shared types and constants of the serial command retry engine.
// Used by every module of the block; depends on nothing.
package scre_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] OP_SUBMIT     = 3'd0;
    localparam logic [2:0] OP_RX         = 3'd1;
    localparam logic [2:0] OP_TICK       = 3'd2;
    localparam logic [2:0] OP_LINK_ERR   = 3'd3;
    localparam logic [2:0] OP_WRITE_DONE = 3'd4;

    localparam logic [2:0] KIND_TX   = 3'd0;
    localparam logic [2:0] KIND_RESP = 3'd1;
    localparam logic [2:0] KIND_DONE = 3'd2;
    localparam logic [2:0] KIND_FAIL = 3'd3;
    localparam logic [2:0] KIND_DROP = 3'd4;

    localparam logic [1:0] CFG_ATTEMPT_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_SETPOINT_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_SETTINGS_ADDRESS = 2'd2;
    localparam logic [1:0] CFG_UNIT_SPACE       = 2'd3;

    localparam logic [15:0] SETPOINT_MAX    = 16'd575;
    localparam logic [15:0] SETTINGS_MASK   = 16'hFFFC;
    localparam logic [2:0]  PACKET_BYTES    = 3'd5;
    localparam logic [7:0]  FULL_WRITE      = 8'd5;
    localparam logic [7:0]  LOW_SPACE_LIMIT = 8'd4;
    localparam logic [6:0]  COUNT_MAX       = 7'd127;
    localparam logic [3:0]  ATTEMPT_MAX     = 4'd15;
    localparam logic [3:0]  ATTEMPT_RESET   = 4'd3;

    typedef enum logic [2:0] {
        EV_SUBMIT,
        EV_RX,
        EV_TICK,
        EV_LINK_ERR,
        EV_WRITE_OK,
        EV_WRITE_SHORT,
        EV_NONE
    } ev_class_t;

    typedef struct packed {
        logic [7:0]  start;
        logic [7:0]  space;
        logic [7:0]  address;
        logic [15:0] payload;
        logic        bundle_end;
    } packet_t;

    typedef struct packed {
        logic [11:0] write_timeout;
        logic [11:0] read_timeout;
        logic [11:0] sleep_ticks;
    } timing_t;

    typedef struct packed {
        packet_t pkt;
        timing_t tim;
    } entry_t;

    typedef struct packed {
        ev_class_t ev_class;
        packet_t   pkt;
        timing_t   tim;
        logic [7:0] rx_byte;
    } event_t;

    typedef struct packed {
        logic [3:0] attempt_limit;
        logic [7:0] setpoint_address;
        logic [7:0] settings_address;
        logic [7:0] unit_space;
    } cfg_t;

endpackage

[hdl/serial_command_retry_engine.sv]
// Top level of the serial command retry engine: configuration registers,
// front end and back end. Depends on scre_pkg, scre_front and scre_back.
//
//  Channel   Signals                            Direction  Carries
//  in        in_valid / in_ready + 11 fields    inbound    one event word
//  out       out_valid / out_ready + 8 fields   outbound   one result word
//  cfg       cfg_valid / cfg_ready, index/data  inbound    one register write
//
// A word that causes no result (ignored events, queueing while busy) is consumed
// in the back end's event state. Starting a queued packet goes through memory
// read, load and attempt set-up before its five transmit bytes, and discarding a
// failed bundle reads and checks each entry in turn, both through the single read
// port of the packet queue memory.
// Reset is asynchronous and clears all control state; the queue needs no clearing.
// A stalled output holds the back end only in states that emit a result, while the
// two-word event buffer of the front end keeps accepting input until it is full.
module serial_command_retry_engine
    import scre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [7:0]  start_byte,
    input  logic [7:0]  space_id,
    input  logic [7:0]  reg_address,
    input  logic [15:0] payload,
    input  logic        bundle_end,
    input  logic [11:0] write_timeout,
    input  logic [11:0] read_timeout,
    input  logic [11:0] sleep_ticks,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  write_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [7:0]  resp_start,
    output logic [7:0]  resp_space,
    output logic [7:0]  resp_address,
    output logic [15:0] resp_payload,
    output logic [6:0]  bundle_count,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers. The user must write them only while the engine is idle;
    // the block does not enforce this and takes every write at once.
    cfg_t   cfg_reg, cfg_next;
    logic   ev_valid;
    logic   ev_ready;
    event_t ev;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ATTEMPT_LIMIT:    cfg_next.attempt_limit    = cfg_data[3:0];
                CFG_SETPOINT_ADDRESS: cfg_next.setpoint_address = cfg_data;
                CFG_SETTINGS_ADDRESS: cfg_next.settings_address = cfg_data;
                CFG_UNIT_SPACE:       cfg_next.unit_space       = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attempt_limit    <= ATTEMPT_RESET;
            cfg_reg.setpoint_address <= 8'd0;
            cfg_reg.settings_address <= 8'd0;
            cfg_reg.unit_space       <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end classifies each word and buffers it as an event.
    scre_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .start_byte    (start_byte),
        .space_id      (space_id),
        .reg_address   (reg_address),
        .payload       (payload),
        .bundle_end    (bundle_end),
        .write_timeout (write_timeout),
        .read_timeout  (read_timeout),
        .sleep_ticks   (sleep_ticks),
        .rx_byte       (rx_byte),
        .write_count   (write_count),
        .ev_valid      (ev_valid),
        .ev_ready      (ev_ready),
        .ev            (ev)
    );

    // The back end owns the packet queue and the send/retry sequencer.
    scre_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .ev_valid     (ev_valid),
        .ev_ready     (ev_ready),
        .ev           (ev),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .tx_byte      (tx_byte),
        .resp_start   (resp_start),
        .resp_space   (resp_space),
        .resp_address (resp_address),
        .resp_payload (resp_payload),
        .bundle_count (bundle_count),
        .last         (last)
    );

endmodule

[hdl/scre_front.sv]
// Front end: accepts input words, classifies them into events and buffers them.
// Depends on scre_pkg.
module scre_front
    import scre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [7:0]  start_byte,
    input  logic [7:0]  space_id,
    input  logic [7:0]  reg_address,
    input  logic [15:0] payload,
    input  logic        bundle_end,
    input  logic [11:0] write_timeout,
    input  logic [11:0] read_timeout,
    input  logic [11:0] sleep_ticks,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  write_count,
    output logic        ev_valid,
    input  logic        ev_ready,
    output event_t      ev
);

    event_t     ev_buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    event_t     ev_in;
    logic       push, pop;

    // Opcodes outside the defined set carry no action and are dropped here.
    always_comb
    begin
        ev_in.pkt.start      = start_byte;
        ev_in.pkt.space      = space_id;
        ev_in.pkt.address    = reg_address;
        ev_in.pkt.payload    = payload;
        ev_in.pkt.bundle_end = bundle_end;
        ev_in.tim.write_timeout = write_timeout;
        ev_in.tim.read_timeout  = read_timeout;
        ev_in.tim.sleep_ticks   = sleep_ticks;
        ev_in.rx_byte        = rx_byte;
        unique case (opcode)
            OP_SUBMIT:     ev_in.ev_class = EV_SUBMIT;
            OP_RX:         ev_in.ev_class = EV_RX;
            OP_TICK:       ev_in.ev_class = EV_TICK;
            OP_LINK_ERR:   ev_in.ev_class = EV_LINK_ERR;
            OP_WRITE_DONE: ev_in.ev_class = (write_count == FULL_WRITE) ? EV_WRITE_OK
                                                                        : EV_WRITE_SHORT;
            default:       ev_in.ev_class = EV_NONE;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign ev_valid = (count_reg != 2'd0);
    assign ev       = ev_buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready && (ev_in.ev_class != EV_NONE);
    assign pop      = ev_valid && ev_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ev_buf_reg[wr_ptr_reg] <= ev_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/scre_back.sv]
// Back end: packet queue, retry sequencer and registered result stage.
// Depends on scre_pkg.
module scre_back
    import scre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        ev_valid,
    output logic        ev_ready,
    input  event_t      ev,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [7:0]  resp_start,
    output logic [7:0]  resp_space,
    output logic [7:0]  resp_address,
    output logic [15:0] resp_payload,
    output logic [6:0]  bundle_count,
    output logic        last
);

    localparam logic [3:0] S_EVT  = 4'd0;
    localparam logic [3:0] S_RESP = 4'd1;
    localparam logic [3:0] S_FIN  = 4'd2;
    localparam logic [3:0] S_PUMP = 4'd3;
    localparam logic [3:0] S_LOAD = 4'd4;
    localparam logic [3:0] S_ATT  = 4'd5;
    localparam logic [3:0] S_TX   = 4'd6;
    localparam logic [3:0] S_DREQ = 4'd7;
    localparam logic [3:0] S_DCHK = 4'd8;
    localparam logic [3:0] S_DROP = 4'd9;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WRITE = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;
    localparam logic [1:0] PH_SLEEP = 2'd3;

    entry_t queue_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    logic [3:0]      state_reg, state_next;
    logic [1:0]      phase_reg, phase_next;
    logic [QA_W-1:0] head_reg, head_next;
    logic [QA_W-1:0] tail_reg, tail_next;
    logic [QF_W-1:0] fill_reg, fill_next;
    packet_t         cur_pkt_reg, cur_pkt_next;
    timing_t         cur_tim_reg, cur_tim_next;
    logic [11:0]     countdown_reg, countdown_next;
    logic [3:0]      attempts_reg, attempts_next;
    logic [39:0]     rbuf_reg, rbuf_next;
    logic [2:0]      rfill_reg, rfill_next;
    logic [6:0]      sent_reg, sent_next;
    logic [6:0]      replies_reg, replies_next;
    logic [39:0]     resp_reg, resp_next;
    logic [2:0]      tx_idx_reg, tx_idx_next;

    logic            out_valid_reg, out_valid_next;
    logic [2:0]      kind_reg;
    logic [7:0]      tx_byte_reg;
    logic [39:0]     resp_out_reg;
    logic [6:0]      count_out_reg;
    logic            last_reg;

    logic            out_free;
    logic            emit;
    logic [2:0]      e_kind;
    logic [7:0]      e_tx;
    logic [39:0]     e_resp;
    logic [6:0]      e_cnt;
    logic            e_last;
    logic            mem_we, mem_re;
    logic [3:0]      lim;
    logic [39:0]     buf_new;
    logic [15:0]     pay_adj;

    function automatic logic [QA_W-1:0] ptr_inc(input logic [QA_W-1:0] p);
        ptr_inc = (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + QA_W'(1);
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign ev_ready = (state_reg == S_EVT);
    assign lim      = (cfg.attempt_limit == 4'd0) ? 4'd1 : cfg.attempt_limit;
    assign buf_new  = rbuf_reg | ({32'd0, ev.rx_byte} << {rfill_reg, 3'b000});

    always_comb
    begin
        pay_adj = cur_pkt_reg.payload;
        if (cur_pkt_reg.address == cfg.setpoint_address &&
            cur_pkt_reg.space < LOW_SPACE_LIMIT && pay_adj > SETPOINT_MAX)
        begin
            pay_adj = SETPOINT_MAX;
        end
        if (cur_pkt_reg.address == cfg.settings_address &&
            cur_pkt_reg.space == cfg.unit_space)
        begin
            pay_adj = pay_adj & SETTINGS_MASK;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        cur_pkt_next   = cur_pkt_reg;
        cur_tim_next   = cur_tim_reg;
        countdown_next = countdown_reg;
        attempts_next  = attempts_reg;
        rbuf_next      = rbuf_reg;
        rfill_next     = rfill_reg;
        sent_next      = sent_reg;
        replies_next   = replies_reg;
        resp_next      = resp_reg;
        tx_idx_next    = tx_idx_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        emit           = 1'b0;
        e_kind         = KIND_TX;
        e_tx           = 8'd0;
        e_resp         = 40'd0;
        e_cnt          = 7'd0;
        e_last         = 1'b0;

        unique case (state_reg)
            S_EVT:
            begin
                if (ev_valid)
                begin
                    unique case (ev.ev_class)
                        EV_SUBMIT:
                        begin
                            if (fill_reg >= QF_W'(QUEUE_DEPTH))
                            begin
                                state_next = S_DROP;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = ptr_inc(tail_reg);
                                fill_next = fill_reg + QF_W'(1);
                                if (phase_reg == PH_IDLE)
                                begin
                                    state_next = S_PUMP;
                                end
                            end
                        end
                        EV_RX:
                        begin
                            if (phase_reg == PH_WRITE || phase_reg == PH_READ)
                            begin
                                if (rfill_reg == PACKET_BYTES - 3'd1)
                                begin
                                    rbuf_next  = 40'd0;
                                    rfill_next = 3'd0;
                                    if (buf_new[7:0]   != cur_pkt_reg.start ||
                                        buf_new[15:8]  != cur_pkt_reg.space ||
                                        buf_new[23:16] != cur_pkt_reg.address)
                                    begin
                                        state_next = S_ATT;
                                    end
                                    else
                                    begin
                                        resp_next     = buf_new;
                                        attempts_next = 4'd0;
                                        if (replies_reg != COUNT_MAX)
                                        begin
                                            replies_next = replies_reg + 7'd1;
                                        end
                                        state_next = S_RESP;
                                    end
                                end
                                else
                                begin
                                    rbuf_next  = buf_new;
                                    rfill_next = rfill_reg + 3'd1;
                                end
                            end
                        end
                        EV_TICK:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                if (countdown_reg <= 12'd1)
                                begin
                                    countdown_next = 12'd0;
                                    if (phase_reg == PH_SLEEP)
                                    begin
                                        state_next = S_FIN;
                                    end
                                    else
                                    begin
                                        rbuf_next  = 40'd0;
                                        rfill_next = 3'd0;
                                        state_next = S_ATT;
                                    end
                                end
                                else
                                begin
                                    countdown_next = countdown_reg - 12'd1;
                                end
                            end
                        end
                        EV_LINK_ERR:
                        begin
                            if (phase_reg == PH_WRITE || phase_reg == PH_READ)
                            begin
                                rbuf_next  = 40'd0;
                                rfill_next = 3'd0;
                                state_next = S_ATT;
                            end
                        end
                        EV_WRITE_OK:
                        begin
                            if (phase_reg == PH_WRITE)
                            begin
                                phase_next     = PH_READ;
                                countdown_next = cur_tim_reg.read_timeout;
                            end
                        end
                        EV_WRITE_SHORT:
                        begin
                            if (phase_reg == PH_WRITE)
                            begin
                                state_next = S_ATT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DROP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_DROP;
                    e_last     = 1'b1;
                    state_next = S_EVT;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_RESP;
                    e_resp = resp_reg;
                    e_last = !(cur_tim_reg.sleep_ticks == 12'd0 &&
                               (cur_pkt_reg.bundle_end || fill_reg != '0));
                    if (cur_tim_reg.sleep_ticks == 12'd0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        phase_next     = PH_SLEEP;
                        countdown_next = cur_tim_reg.sleep_ticks;
                        state_next     = S_EVT;
                    end
                end
            end
            S_FIN:
            begin
                phase_next     = PH_IDLE;
                countdown_next = 12'd0;
                if (!cur_pkt_reg.bundle_end)
                begin
                    state_next = S_PUMP;
                end
                else if (out_free)
                begin
                    emit         = 1'b1;
                    e_kind       = KIND_DONE;
                    e_cnt        = replies_reg;
                    e_last       = (fill_reg == '0);
                    replies_next = 7'd0;
                    sent_next    = 7'd0;
                    state_next   = S_PUMP;
                end
            end
            S_PUMP:
            begin
                if (fill_reg == '0)
                begin
                    state_next = S_EVT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cur_pkt_next  = rd_data_reg.pkt;
                cur_tim_next  = rd_data_reg.tim;
                head_next     = ptr_inc(head_reg);
                fill_next     = fill_reg - QF_W'(1);
                attempts_next = 4'd0;
                if (sent_reg == 7'd0)
                begin
                    replies_next = 7'd0;
                end
                if (sent_reg != COUNT_MAX)
                begin
                    sent_next = sent_reg + 7'd1;
                end
                state_next = S_ATT;
            end
            S_ATT:
            begin
                if (attempts_reg >= lim)
                begin
                    if (out_free)
                    begin
                        emit           = 1'b1;
                        e_kind         = KIND_FAIL;
                        e_cnt          = replies_reg;
                        e_last         = 1'b1;
                        replies_next   = 7'd0;
                        sent_next      = 7'd0;
                        attempts_next  = 4'd0;
                        rbuf_next      = 40'd0;
                        rfill_next     = 3'd0;
                        countdown_next = 12'd0;
                        phase_next     = PH_IDLE;
                        state_next     = cur_pkt_reg.bundle_end ? S_EVT : S_DREQ;
                    end
                end
                else
                begin
                    if (attempts_reg != ATTEMPT_MAX)
                    begin
                        attempts_next = attempts_reg + 4'd1;
                    end
                    cur_pkt_next.payload = pay_adj;
                    phase_next           = PH_WRITE;
                    countdown_next       = cur_tim_reg.write_timeout;
                    tx_idx_next          = 3'd0;
                    state_next           = S_TX;
                end
            end
            S_TX:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_TX;
                    unique case (tx_idx_reg)
                        3'd0:    e_tx = cur_pkt_reg.start;
                        3'd1:    e_tx = cur_pkt_reg.space;
                        3'd2:    e_tx = cur_pkt_reg.address;
                        3'd3:    e_tx = cur_pkt_reg.payload[7:0];
                        default: e_tx = cur_pkt_reg.payload[15:8];
                    endcase
                    e_last      = (tx_idx_reg == PACKET_BYTES - 3'd1);
                    tx_idx_next = tx_idx_reg + 3'd1;
                    if (tx_idx_reg == PACKET_BYTES - 3'd1)
                    begin
                        state_next = S_EVT;
                    end
                end
            end
            S_DREQ:
            begin
                if (fill_reg == '0)
                begin
                    state_next = S_EVT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_DCHK;
                end
            end
            S_DCHK:
            begin
                head_next  = ptr_inc(head_reg);
                fill_next  = fill_reg - QF_W'(1);
                state_next = rd_data_reg.pkt.bundle_end ? S_EVT : S_DREQ;
            end
            default:
            begin
                state_next = S_EVT;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[tail_reg] <= '{pkt: ev.pkt, tim: ev.tim};
        end
        if (mem_re)
        begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg      <= e_kind;
            tx_byte_reg   <= e_tx;
            resp_out_reg  <= e_resp;
            count_out_reg <= e_cnt;
            last_reg      <= e_last;
        end
        resp_reg    <= resp_next;
        tx_idx_reg  <= tx_idx_next;
        cur_tim_reg <= cur_tim_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EVT;
            phase_reg     <= PH_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            cur_pkt_reg   <= '0;
            countdown_reg <= 12'd0;
            attempts_reg  <= 4'd0;
            rbuf_reg      <= 40'd0;
            rfill_reg     <= 3'd0;
            sent_reg      <= 7'd0;
            replies_reg   <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            cur_pkt_reg   <= cur_pkt_next;
            countdown_reg <= countdown_next;
            attempts_reg  <= attempts_next;
            rbuf_reg      <= rbuf_next;
            rfill_reg     <= rfill_next;
            sent_reg      <= sent_next;
            replies_reg   <= replies_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign tx_byte      = tx_byte_reg;
    assign resp_start   = resp_out_reg[7:0];
    assign resp_space   = resp_out_reg[15:8];
    assign resp_address = resp_out_reg[23:16];
    assign resp_payload = resp_out_reg[39:24];
    assign bundle_count = count_out_reg;
    assign last         = last_reg;

endmodule

[hdl/scre_checker.sv]
// Port-level checker of the serial command retry engine, bound to the top level.
// Depends on scre_pkg and serial_command_retry_engine_macros.svh.
`include "serial_command_retry_engine_macros.svh"

module scre_checker
    import scre_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  resp_start,
    input logic [7:0]  resp_space,
    input logic [7:0]  resp_address,
    input logic [15:0] resp_payload,
    input logic [6:0]  bundle_count,
    input logic        last
);

    // A stalled result word keeps its kind and marker.
    `SCRE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(last), "result word changed while stalled")

    // A failure or a dropped submit always ends the results of its word.
    `SCRE_ASSERT_IMP(a_final_kinds, out_valid && (kind == KIND_FAIL || kind == KIND_DROP), last, "fail or drop not marked last")

    // Response fields are zero on every other kind.
    `SCRE_ASSERT_IMP(a_resp_zero, out_valid && kind != KIND_RESP, resp_start == 8'd0 && resp_space == 8'd0 && resp_address == 8'd0 && resp_payload == 16'd0, "response fields set on non-response")

    // The bundle count appears only on bundle done or failed.
    `SCRE_ASSERT_IMP(a_count_zero, out_valid && kind != KIND_DONE && kind != KIND_FAIL, bundle_count == 7'd0, "bundle count set outside bundle end")

endmodule

bind serial_command_retry_engine scre_checker u_scre_checker (.*);
